### sv/dssi_pkg.sv
package dssi_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_OVERLAP   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // One span as offered on the input channel and as held in the store.
    typedef struct packed {
        logic [63:0] span_offset;
        logic [63:0] span_size;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] span_count;
    } out_item_t;

    // Candidate span with its saturated end precomputed.
    typedef struct packed {
        in_item_t    span;
        logic [63:0] span_end;
    } cand_t;

    // Outcome of comparing one stored entry against the candidate.
    typedef struct packed {
        logic less;   // entry orders strictly before the candidate
        logic equal;  // entry is an exact copy of the candidate
        logic meet;   // half-open ranges overlap
    } cmp_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SUCC_RD,
        S_SUCC_CMP,
        S_PRED_RD,
        S_PRED_CMP,
        S_DECIDE,
        S_SHIFT,
        S_WRITE_NEW,
        S_DONE
    } state_t;

endpackage

### sv/disjoint_span_set_insert_unit.sv
// Channel  | Ports                      | Transfer carries
// ---------+----------------------------+-----------------------------------
// input    | s_valid, s_ready, s_data   | one candidate span (offset, size)
// result   | m_valid, m_ready, m_data   | status and distinct span count
//
// Each item runs a binary search, each probe going through the registered
// read port of the span store, then two neighbour checks, then, to open the
// insertion slot, a shift of the tail of the store by one entry per cycle.
// An empty span skips all of these steps.
// Reset (aresetn low, synchronous) empties the store; no clearing pass runs.
// The result register lets a new span be taken while the previous result
// still waits; a finished item waits in its final state until that register
// is free.
module disjoint_span_set_insert_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dssi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dssi_pkg::out_item_t m_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    dssi_pkg::state_t    state_reg, state_next;
    dssi_pkg::cand_t     cand_reg;
    dssi_pkg::status_t   status_reg;
    dssi_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;
    logic [CW-1:0]       lo_reg, hi_reg, count_reg;
    logic [AW-1:0]       k_reg;

    // Store ports and compare results.
    logic                rd_addr_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    dssi_pkg::in_item_t  wr_data;
    dssi_pkg::in_item_t  rd_data;
    dssi_pkg::cmp_res_t  cmp;

    // Search arithmetic.
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid_full;
    logic [CW-1:0]       lo_new, hi_new;
    logic [CW-1:0]       pos_m1;
    logic [AW-1:0]       k_m1, k_m2;
    logic                store_full;
    logic                out_free;
    logic [64:0]         cand_sum;
    logic                s_fire;

    assign mid_sum    = (CW+1)'(lo_reg) + (CW+1)'(hi_reg);
    assign mid_full   = mid_sum[CW:1];
    assign lo_new     = cmp.less ? (mid_full + CW'(1)) : lo_reg;
    assign hi_new     = cmp.less ? hi_reg : mid_full;
    assign pos_m1     = lo_reg - CW'(1);
    assign k_m1       = k_reg - AW'(1);
    assign k_m2       = k_reg - AW'(2);
    assign store_full = (count_reg >= CW'(CAPACITY));
    assign out_free   = !m_valid_reg || m_ready;
    assign cand_sum   = {1'b0, s_data.span_offset} + {1'b0, s_data.span_size};
    assign s_ready    = (state_reg == dssi_pkg::S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    dssi_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The compare unit always looks at the word read in the previous cycle.
    dssi_cmp u_cmp (
        .entry (rd_data),
        .cand  (cand_reg),
        .res   (cmp)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dssi_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (s_data.span_size == '0) begin
                        state_next = dssi_pkg::S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = dssi_pkg::S_SUCC_RD;
                    end else begin
                        state_next = dssi_pkg::S_SEARCH_RD;
                    end
                end
            end
            dssi_pkg::S_SEARCH_RD:  state_next = dssi_pkg::S_SEARCH_CMP;
            dssi_pkg::S_SEARCH_CMP: begin
                state_next = (lo_new == hi_new) ? dssi_pkg::S_SUCC_RD
                                                : dssi_pkg::S_SEARCH_RD;
            end
            dssi_pkg::S_SUCC_RD: begin
                state_next = (lo_reg < count_reg) ? dssi_pkg::S_SUCC_CMP
                                                  : dssi_pkg::S_PRED_RD;
            end
            dssi_pkg::S_SUCC_CMP: begin
                state_next = (cmp.equal || cmp.meet) ? dssi_pkg::S_DONE
                                                     : dssi_pkg::S_PRED_RD;
            end
            dssi_pkg::S_PRED_RD: begin
                state_next = (lo_reg != '0) ? dssi_pkg::S_PRED_CMP
                                            : dssi_pkg::S_DECIDE;
            end
            dssi_pkg::S_PRED_CMP: begin
                state_next = cmp.meet ? dssi_pkg::S_DONE : dssi_pkg::S_DECIDE;
            end
            dssi_pkg::S_DECIDE: begin
                priority if (store_full) begin
                    state_next = dssi_pkg::S_DONE;
                end else if (lo_reg == count_reg) begin
                    state_next = dssi_pkg::S_WRITE_NEW;
                end else begin
                    state_next = dssi_pkg::S_SHIFT;
                end
            end
            dssi_pkg::S_SHIFT: begin
                if (CW'(k_m1) == lo_reg) begin
                    state_next = dssi_pkg::S_WRITE_NEW;
                end
            end
            dssi_pkg::S_WRITE_NEW: state_next = dssi_pkg::S_DONE;
            dssi_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = dssi_pkg::S_IDLE;
                end
            end
            default: state_next = dssi_pkg::S_IDLE;
        endcase
    end

    // Store port drive for each state.
    always_comb begin
        rd_addr_en = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = rd_data;
        unique case (state_reg)
            dssi_pkg::S_SEARCH_RD: begin
                rd_addr_en = 1'b1;
                rd_addr    = mid_full[AW-1:0];
            end
            dssi_pkg::S_SUCC_RD: begin
                rd_addr_en = 1'b1;
                rd_addr    = lo_reg[AW-1:0];
            end
            dssi_pkg::S_PRED_RD: begin
                rd_addr_en = 1'b1;
                rd_addr    = pos_m1[AW-1:0];
            end
            dssi_pkg::S_DECIDE: begin
                // Fetch the last entry, the first one to move up.
                rd_addr_en = 1'b1;
                rd_addr    = count_reg[AW-1:0] - AW'(1);
            end
            dssi_pkg::S_SHIFT: begin
                // Move the word read last cycle up by one and fetch the next.
                wr_en      = 1'b1;
                rd_addr_en = 1'b1;
                rd_addr    = k_m2;
            end
            dssi_pkg::S_WRITE_NEW: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[AW-1:0];
                wr_data = cand_reg.span;
            end
            default: begin
                rd_addr_en = 1'b0;
            end
        endcase
        if (!rd_addr_en) begin
            rd_addr = '0;
        end
    end

    // Sequencer state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dssi_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == dssi_pkg::S_WRITE_NEW) begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == dssi_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current item; these carry no reset.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dssi_pkg::S_IDLE: begin
                if (s_fire) begin
                    cand_reg.span     <= s_data;
                    cand_reg.span_end <= cand_sum[64] ? {64{1'b1}} : cand_sum[63:0];
                    lo_reg            <= '0;
                    hi_reg            <= count_reg;
                    status_reg        <= dssi_pkg::ST_EMPTY;
                end
            end
            dssi_pkg::S_SEARCH_CMP: begin
                lo_reg <= lo_new;
                hi_reg <= hi_new;
            end
            dssi_pkg::S_SUCC_CMP: begin
                // An exact copy wins over the overlap it would also report.
                if (cmp.equal) begin
                    status_reg <= dssi_pkg::ST_DUPLICATE;
                end else if (cmp.meet) begin
                    status_reg <= dssi_pkg::ST_OVERLAP;
                end
            end
            dssi_pkg::S_PRED_CMP: begin
                if (cmp.meet) begin
                    status_reg <= dssi_pkg::ST_OVERLAP;
                end
            end
            dssi_pkg::S_DECIDE: begin
                k_reg <= count_reg[AW-1:0];
                if (store_full) begin
                    status_reg <= dssi_pkg::ST_FULL;
                end
            end
            dssi_pkg::S_SHIFT: begin
                k_reg <= k_m1;
            end
            dssi_pkg::S_WRITE_NEW: begin
                status_reg <= dssi_pkg::ST_INSERTED;
            end
            dssi_pkg::S_DONE: begin
                if (out_free) begin
                    m_data_reg.status     <= status_reg;
                    m_data_reg.span_count <= 7'(count_reg);
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

endmodule

### sv/dssi_store.sv
// Span store: one write port and one read port, read data registered.
module dssi_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  dssi_pkg::in_item_t wr_data,
    input  logic [AW-1:0]      rd_addr,
    output dssi_pkg::in_item_t rd_data
);

    dssi_pkg::in_item_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/dssi_cmp.sv
// Shared compare unit: orders a stored entry against the candidate and
// checks the two half-open ranges for overlap.
module dssi_cmp (
    input  dssi_pkg::in_item_t entry,
    input  dssi_pkg::cand_t    cand,
    output dssi_pkg::cmp_res_t res
);

    logic [64:0] entry_sum;
    logic [63:0] entry_end;
    logic        off_eq;

    assign entry_sum = {1'b0, entry.span_offset} + {1'b0, entry.span_size};
    assign entry_end = entry_sum[64] ? {64{1'b1}} : entry_sum[63:0];
    assign off_eq    = (entry.span_offset == cand.span.span_offset);

    assign res.less  = off_eq ? (entry.span_size < cand.span.span_size)
                              : (entry.span_offset < cand.span.span_offset);
    assign res.equal = off_eq && (entry.span_size == cand.span.span_size);
    assign res.meet  = (entry.span_offset < cand.span_end) &&
                       (cand.span.span_offset < entry_end);

endmodule

### bench/disjoint_span_set_insert_unit_tb.sv
module disjoint_span_set_insert_unit_tb;

    // The store is kept at its usual size. The block's slowest item is a full
    // binary search plus a shift of every stored entry.
    localparam int          SPAN_CAP     = 64;
    localparam int          SETTLE_TIME  = 100;
    localparam int          STALL_LIMIT  = 2000;
    localparam logic [63:0] TOP          = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    dssi_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    dssi_pkg::out_item_t m_data;

    // Our own copy of the sorted span store, updated as each input transfer
    // is accepted.
    logic [63:0] held_off [SPAN_CAP];
    logic [63:0] held_len [SPAN_CAP];
    int          held_count = 0;

    // Outcomes predicted for accepted spans whose result transfer has not
    // yet been seen, oldest first.
    dssi_pkg::out_item_t pending_outcomes[$];

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    disjoint_span_set_insert_unit #(
        .CAPACITY(SPAN_CAP)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // End of the half-open range covered by a span, held at the all-ones
    // value when the sum would run past the top of the address space.
    function automatic logic [63:0] span_end(logic [63:0] off, logic [63:0] len);
        logic [64:0] sum;
        sum = {1'b0, off} + {1'b0, len};
        return sum[64] ? TOP : sum[63:0];
    endfunction

    // Two spans overlap when each one starts before the other one ends.
    function automatic logic spans_overlap(logic [63:0] a_off, logic [63:0] a_len,
                                           logic [63:0] b_off, logic [63:0] b_len);
        return (a_off < span_end(b_off, b_len)) && (b_off < span_end(a_off, a_len));
    endfunction

    // Works out the result of offering one span to the store and applies any
    // insertion to our copy. The store is ordered by offset, then by size,
    // and only the entries either side of the sorted position are examined
    // for overlap: the one at the position first, then the one before it.
    function automatic dssi_pkg::out_item_t insert_outcome(logic [63:0] off,
                                                           logic [63:0] len);
        int                  pos;
        int                  i;
        dssi_pkg::out_item_t res;
        pos = 0;
        if (len == 64'd0) begin
            res.status = dssi_pkg::ST_EMPTY;
        end else begin
            while (pos < held_count &&
                   (held_off[pos] != off ? held_off[pos] < off : held_len[pos] < len))
                pos++;
            if (pos < held_count && held_off[pos] == off && held_len[pos] == len) begin
                res.status = dssi_pkg::ST_DUPLICATE;
            end else if (pos < held_count &&
                         spans_overlap(held_off[pos], held_len[pos], off, len)) begin
                res.status = dssi_pkg::ST_OVERLAP;
            end else if (pos > 0 &&
                         spans_overlap(held_off[pos-1], held_len[pos-1], off, len)) begin
                res.status = dssi_pkg::ST_OVERLAP;
            end else if (held_count >= SPAN_CAP) begin
                res.status = dssi_pkg::ST_FULL;
            end else begin
                for (i = held_count; i > pos; i--) begin
                    held_off[i] = held_off[i-1];
                    held_len[i] = held_len[i-1];
                end
                held_off[pos] = off;
                held_len[pos] = len;
                held_count++;
                res.status = dssi_pkg::ST_INSERTED;
            end
        end
        res.span_count = held_count[6:0];
        return res;
    endfunction

    // Chooses a span for the random traffic. Most spans are built from what
    // the store already holds, so that duplicates, overlaps and touching
    // neighbours turn up often; the rest are fresh spans that fit in a gap,
    // empty spans, and raw noise that exercises the upper bits of the size.
    function automatic dssi_pkg::in_item_t pick_random_span();
        int                 kind;
        int                 idx;
        logic [63:0]        base;
        logic [63:0]        len;
        logic [63:0]        gap;
        dssi_pkg::in_item_t item;
        kind = $urandom_range(99);
        idx  = (held_count > 0) ? $urandom_range(held_count - 1) : 0;
        base = held_off[idx];
        len  = held_len[idx];
        item.span_offset = {$urandom, $urandom};
        item.span_size   = 64'($urandom_range(1, 65535));
        if (kind < 10) begin
            item.span_size = '0;
        end else if (kind < 32 || held_count == 0) begin
            // Fresh span; now and then one that starts exactly where a
            // stored span ends, which must not count as an overlap.
            if (held_count > 0 && $urandom_range(3) == 0) begin
                item.span_offset = span_end(base, len);
                item.span_size   = 64'($urandom_range(1, 256));
            end
        end else if (kind < 52) begin
            item.span_offset = base;
            item.span_size   = len;
        end else if (kind < 80) begin
            case ($urandom_range(2))
                0: begin
                    item.span_offset = base + ({$urandom, $urandom} % len);
                    item.span_size   = $urandom_range(1, 1024);
                end
                1: begin
                    gap = 64'($urandom_range(1, 256));
                    if (base >= gap) begin
                        item.span_offset = base - gap;
                        item.span_size   = gap + $urandom_range(1, 16);
                    end else begin
                        item.span_offset = base;
                        item.span_size   = len + 1;
                    end
                end
                default: begin
                    item.span_offset = base;
                    item.span_size   = len + $urandom_range(1, 16);
                end
            endcase
        end else begin
            item.span_size = {$urandom, $urandom} >> $urandom_range(0, 63);
        end
        return item;
    endfunction

    // The receiver decides afresh at every falling edge whether it will take
    // a result transfer in the coming cycle.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Everything that happens at a rising edge is observed here, in one
    // place: accepted spans feed the predictor before any result of the same
    // edge is checked, and the watchdog sees both channels.
    always @(posedge aclk) begin : observe
        dssi_pkg::out_item_t want;
        if (aresetn && s_valid && s_ready)
            pending_outcomes.push_back(insert_outcome(s_data.span_offset,
                                                      s_data.span_size));
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding, status %0d count %0d",
                         $time, m_data.status, m_data.span_count);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.span_count !== want.span_count) begin
                    $display("%0t: span_count mismatch: expected %0d, actual %0d",
                             $time, want.span_count, m_data.span_count);
                    fail_count++;
                end
            end
        end
        // Any transfer on either channel counts as progress.
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offers one span and returns at the rising edge that accepts it. Valid
    // is left high afterwards, so back-to-back spans keep it high throughout
    // and each falling edge carries a single assignment to it.
    task automatic send_span(input logic [63:0] off, input logic [63:0] len);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_data.span_offset <= off;
        s_data.span_size   <= len;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the sender back until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // Empty spans are answered before anything else, whatever the offset.
    task automatic test_empty_spans();
        send_span(64'd0, 64'd0);
        send_span(TOP, 64'd0);
    endtask

    // Spans at both ends of the address space. The span that runs to the top
    // has its end saturated, and spans that start at the very top cover
    // nothing, so two of them with different sizes can both be stored. The
    // last span here is huge and collides with the saturated one after it.
    task automatic test_extreme_spans();
        send_span(64'd0, 64'd1);
        send_span(64'd1, 64'd1);
        send_span(TOP - 64'd15, 64'd16);
        send_span(TOP, 64'd5);
        send_span(TOP, 64'd7);
        send_span(64'd2, TOP);
    endtask

    // Exact copies of stored spans are reported as duplicates rather than stored again.
    task automatic test_duplicates();
        send_span(64'd0, 64'd1);
        send_span(TOP, 64'd5);
        send_span(TOP - 64'd15, 64'd16);
    endtask

    // Collisions with the following span and with the preceding one, plus a
    // span that merely touches the end of its predecessor.
    task automatic test_overlaps();
        send_span(64'd0, 64'd2);
        send_span(64'h1000, 64'h100);
        send_span(64'h10FF, 64'h10);
        send_span(64'h0F80, 64'h100);
        send_span(64'h1100, 64'h10);
        send_span(TOP - 64'd16, 64'd2);
    endtask

    // A run of random spans under the given idling of the two channels. The
    // store only ever grows, so over the whole run it fills up and the later
    // traffic meets a full store.
    task automatic test_random_mix(input int send_pct, input int recv_pct,
                                   input int n_items);
        dssi_pkg::in_item_t item;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items) begin
            item = pick_random_span();
            send_span(item.span_offset, item.span_size);
        end
        wait_drained();
    endtask

    initial begin : run
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        send_idle_pct = 32;
        recv_idle_pct = 49;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_spans();
        test_extreme_spans();
        test_duplicates();
        test_overlaps();
        wait_drained();

        test_random_mix(32, 49, 128);
        test_random_mix(49, 32, 128);
        test_random_mix(0, 0, 128);

        // Give the block time to show any stray result transfer.
        repeat (SETTLE_TIME) @(posedge aclk);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
